/* src/bba_pkg.sv */
`default_nettype none

package bba_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int POS_W = $clog2(WORD_BITS);
	localparam int IDX_W = WORD_AW + POS_W;
	localparam int FREE_W = $clog2(NUM_BLOCKS + 1);

	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] LAST_VALID = (NUM_BLOCKS % WORD_BITS == 0) ?
		{WORD_BITS{1'b1}} : ((WORD_BITS'(1) << (NUM_BLOCKS % WORD_BITS)) - WORD_BITS'(1));

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_TEST  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_BIT
	} seq_state_t;

	typedef struct packed {
		logic               en;
		logic [WORD_AW-1:0] addr;
		logic [POS_W-1:0]   bit_pos;
		logic               val;
	} map_wr_t;

endpackage

`default_nettype wire

/* src/block_bitmap_allocator.sv */
// Free and test pass through S_BIT; their result beat is registered from that state.
// Allocate reads words 0 to 15 in order in S_SCAN, one 64-bit word per cycle, until it
// finds a free block, then sets that bit in S_COMMIT; a full map reports after word 15.
// busy falls in the cycle of the done strobe, when the next request may be issued.
// The receiver cannot stall: done is high for one cycle only; the result fields hold.
// Reset clears the bitmap flip-flops at once and sets free_q, not the port, to 1024.
`default_nettype none

module block_bitmap_allocator
	import bba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [9:0]  block_index,
	output logic             done,
	output logic      [1:0]  status,
	output logic      [9:0]  result_index,
	output logic             bit_value,
	output logic      [10:0] free_count
);

	logic [WORD_AW-1:0]   rd_addr;
	logic [WORD_BITS-1:0] rd_word;
	map_wr_t              map_wr;

	bba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_word (rd_word),
		.wr      (map_wr)
	);

	bba_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.block_index  (block_index),
		.rd_addr      (rd_addr),
		.rd_word      (rd_word),
		.map_wr       (map_wr),
		.done         (done),
		.status       (status),
		.result_index (result_index),
		.bit_value    (bit_value),
		.free_count   (free_count)
	);

endmodule

`default_nettype wire

/* src/bba_ffz.sv */
`default_nettype none

module bba_ffz
	import bba_pkg::*;
(
	input  wire logic [WORD_BITS-1:0] vec,
	output logic      [POS_W-1:0]     pos
);

	logic [WORD_BITS-1:0] lowest;

	// Isolate the lowest set bit, then encode the one-hot result.
	assign lowest = vec & (~vec + WORD_BITS'(1));

	always_comb begin
		pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				pos = pos | POS_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* src/bba_map.sv */
`default_nettype none

module bba_map
	import bba_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [WORD_AW-1:0]   rd_addr,
	output logic      [WORD_BITS-1:0] rd_word,
	input  wire map_wr_t              wr
);

	logic [WORD_BITS-1:0] mem_q [MAP_WORDS];

	always_comb begin
		if (32'(rd_addr) < MAP_WORDS) begin
			rd_word = mem_q[rd_addr];
		end else begin
			rd_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr.en && (32'(wr.addr) < MAP_WORDS)) begin
			mem_q[wr.addr][wr.bit_pos] <= wr.val;
		end
	end

endmodule

`default_nettype wire

/* src/bba_seq.sv */
`default_nettype none

module bba_seq
	import bba_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           req_type,
	input  wire logic [9:0]           block_index,
	output logic      [WORD_AW-1:0]   rd_addr,
	input  wire logic [WORD_BITS-1:0] rd_word,
	output map_wr_t                   map_wr,
	output logic                      done,
	output logic      [1:0]           status,
	output logic      [9:0]           result_index,
	output logic                      bit_value,
	output logic      [10:0]          free_count
);

	seq_state_t state_q, state_d;

	logic [1:0]           req_q;
	logic [9:0]           echo_q;
	logic                 range_q;
	logic [WORD_AW-1:0]   ptr_q, ptr_d;
	logic [POS_W-1:0]     pos_q;
	logic [WORD_BITS-1:0] freevec_q;
	logic [FREE_W-1:0]    free_q, free_d;

	logic                 done_q;
	status_t              status_q;
	logic [9:0]           rindex_q;
	logic                 bit_q;
	logic [10:0]          fcount_q;

	logic                 res_valid;
	status_t              res_status;
	logic [9:0]           res_index;
	logic                 res_bit;

	logic [IDX_W-1:0]     req_blk;
	logic [WORD_BITS-1:0] scan_free;
	logic [POS_W-1:0]     ffz_pos;
	logic                 cur_bit;

	bba_ffz u_ffz (
		.vec (freevec_q),
		.pos (ffz_pos)
	);

	assign req_blk = IDX_W'(block_index);
	assign rd_addr = ptr_q;
	assign cur_bit = rd_word[pos_q];
	assign scan_free = ~rd_word & ((ptr_q == LAST_WORD) ? LAST_VALID : {WORD_BITS{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= FREE_W'(NUM_BLOCKS);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			done_q  <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (state_q == S_IDLE && start) begin
			req_q   <= req_type;
			echo_q  <= block_index;
			range_q <= 32'(block_index) >= NUM_BLOCKS;
			pos_q   <= req_blk[POS_W-1:0];
		end
		if (state_q == S_SCAN) begin
			freevec_q <= scan_free;
		end
		if (res_valid) begin
			status_q <= res_status;
			rindex_q <= res_index;
			bit_q    <= res_bit;
			fcount_q <= 11'(free_d);
		end
	end

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		free_d     = free_q;
		map_wr     = '0;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_index  = echo_q;
		res_bit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_ALLOC) begin
						ptr_d   = '0;
						state_d = S_SCAN;
					end else begin
						ptr_d   = req_blk[IDX_W-1:POS_W];
						state_d = S_BIT;
					end
				end
			end
			S_SCAN: begin
				if (|scan_free) begin
					state_d = S_COMMIT;
				end else if (ptr_q == LAST_WORD) begin
					res_valid  = 1'b1;
					res_status = ST_FULL;
					res_index  = '0;
					state_d    = S_IDLE;
				end else begin
					ptr_d = ptr_q + WORD_AW'(1);
				end
			end
			S_COMMIT: begin
				map_wr.en      = 1'b1;
				map_wr.addr    = ptr_q;
				map_wr.bit_pos = ffz_pos;
				map_wr.val     = 1'b1;
				if (free_q != '0) begin
					free_d = free_q - FREE_W'(1);
				end
				res_valid = 1'b1;
				res_index = 10'({ptr_q, ffz_pos});
				res_bit   = 1'b1;
				state_d   = S_IDLE;
			end
			S_BIT: begin
				res_valid = 1'b1;
				state_d   = S_IDLE;
				case (req_q)
					REQ_FREE: begin
						if (range_q) begin
							res_status = ST_RANGE;
						end else if (cur_bit) begin
							map_wr.en      = 1'b1;
							map_wr.addr    = ptr_q;
							map_wr.bit_pos = pos_q;
							map_wr.val     = 1'b0;
							if (free_q < FREE_W'(NUM_BLOCKS)) begin
								free_d = free_q + FREE_W'(1);
							end
						end else begin
							res_status = ST_NOT_ALLOC;
						end
					end
					REQ_TEST: begin
						if (range_q) begin
							res_status = ST_RANGE;
						end else begin
							res_bit = cur_bit;
						end
					end
					default: begin
						res_status = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign result_index = rindex_q;
	assign bit_value    = bit_q;
	assign free_count   = fcount_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q != S_IDLE))
		else $error("result produced while idle");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(NUM_BLOCKS))
		else $error("free count above block count");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		map_wr.en |-> (state_q == S_COMMIT || state_q == S_BIT))
		else $error("bitmap written outside commit or bit step");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_FULL) |-> (free_q == '0))
		else $error("full reported with free blocks counted");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |=> (free_q == $past(free_q) - FREE_W'(1)))
		else $error("allocation did not take one block from the count");

endmodule

`default_nettype wire

/* bench/block_bitmap_allocator_checker.sv */
`timescale 1ns / 1ps

module block_bitmap_allocator_checker
	import bba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [9:0]  block_index,
	input  wire logic        done,
	input  wire logic [1:0]  status,
	input  wire logic [9:0]  result_index,
	input  wire logic        bit_value,
	input  wire logic [10:0] free_count,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		status_t     st;
		logic [9:0]  index;
		logic        used;
		logic [10:0] free_left;
	} alloc_result_t;

	logic [NUM_BLOCKS-1:0] used_map;
	logic [FREE_W-1:0]     free_total;
	alloc_result_t         expected_q[$];

	function automatic alloc_result_t predict_request(input logic [1:0] kind,
			input logic [9:0] idx);
		alloc_result_t r;
		int slot;
		r.st = ST_OK;
		r.index = idx;
		r.used = 1'b0;
		if (kind == REQ_ALLOC) begin
			slot = -1;
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				if (slot < 0 && !used_map[i])
					slot = i;
			end
			if (slot >= 0) begin
				used_map[slot] = 1'b1;
				free_total = free_total - 1'b1;
				r.index = slot[9:0];
				r.used = 1'b1;
			end else begin
				r.st = ST_FULL;
				r.index = '0;
			end
		end else if (kind == REQ_FREE) begin
			if (int'(idx) >= NUM_BLOCKS) begin
				r.st = ST_RANGE;
			end else if (used_map[idx]) begin
				used_map[idx] = 1'b0;
				free_total = free_total + 1'b1;
			end else begin
				r.st = ST_NOT_ALLOC;
			end
		end else if (kind == REQ_TEST) begin
			if (int'(idx) >= NUM_BLOCKS)
				r.st = ST_RANGE;
			else
				r.used = used_map[idx];
		end
		r.free_left = 11'(free_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		logic bad;
		if (!arst_n) begin
			used_map = '0;
			free_total = FREE_W'(NUM_BLOCKS);
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					bad = 1'b0;
					if (status !== want.st) begin
						bad = 1'b1;
						$error("status expected %0d got %0d", want.st, status);
					end
					if (result_index !== want.index) begin
						bad = 1'b1;
						$error("result_index expected %0d got %0d", want.index,
							result_index);
					end
					if (bit_value !== want.used) begin
						bad = 1'b1;
						$error("bit_value expected %0d got %0d", want.used, bit_value);
					end
					if (free_count !== want.free_left) begin
						bad = 1'b1;
						$error("free_count expected %0d got %0d", want.free_left,
							free_count);
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_request(req_type, block_index));
			pending <= expected_q.size();
		end
	end

endmodule

/* bench/block_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
	import bba_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1950;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_ALLOC;
	logic [9:0]  block_index = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [9:0]  result_index;
	logic        bit_value;
	logic [10:0] free_count;
	int          fail_count;
	int          pending;
	int          stall_cycles = 0;
	int          items_sent = 0;
	bit          gaps_on = 1'b1;

	block_bitmap_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.block_index(block_index),
		.done(done),
		.status(status),
		.result_index(result_index),
		.bit_value(bit_value),
		.free_count(free_count)
	);

	block_bitmap_allocator_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.block_index(block_index),
		.done(done),
		.status(status),
		.result_index(result_index),
		.bit_value(bit_value),
		.free_count(free_count),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send(input logic [1:0] kind, input logic [9:0] idx);
		bit taken;
		req_type <= kind;
		block_index <= idx;
		taken = 1'b0;
		while (!taken) begin
			start <= !(gaps_on && $urandom_range(99) < 11);
			@(posedge clk);
			taken = start && !busy;
		end
		items_sent++;
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int roll;
		int net_alloc;
		int free_hi;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send(REQ_TEST, 10'd0);
		send(REQ_TEST, 10'd1023);
		send(REQ_FREE, 10'd0);
		send(REQ_FREE, 10'd1023);
		send(REQ_NONE, 10'd1023);
		send(REQ_NONE, 10'd0);
		send(REQ_ALLOC, 10'd1023);
		send(REQ_ALLOC, 10'd0);
		send(REQ_TEST, 10'd0);
		send(REQ_TEST, 10'd1);
		send(REQ_FREE, 10'd0);
		send(REQ_TEST, 10'd0);
		send(REQ_ALLOC, 10'h2AA);
		send(REQ_FREE, 10'd1);
		send(REQ_FREE, 10'd1);
		send(REQ_ALLOC, 10'h155);
		send(REQ_ALLOC, 10'd0);
		send(REQ_TEST, 10'd2);
		send(REQ_FREE, 10'd2);
		send(REQ_TEST, 10'd2);

		// The sender holds off here until the block has answered everything.
		wait_all_results();

		// Mostly allocations, enough of them to fill the map and then hit it while full.
		net_alloc = 0;
		while (net_alloc < NUM_BLOCKS + 20) begin
			gaps_on = !(items_sent >= 400 && items_sent < 750);
			roll = $urandom_range(99);
			if (roll < 86) begin
				send(REQ_ALLOC, 10'($urandom));
				net_alloc++;
			end else if (roll < 93) begin
				free_hi = (net_alloc < 0) ? 8 : ((net_alloc > 1015) ? 1023 : net_alloc + 8);
				send(REQ_FREE, 10'($urandom_range(free_hi)));
				net_alloc--;
			end else if (roll < 98) begin
				send(REQ_TEST, 10'($urandom));
			end else begin
				send(REQ_NONE, 10'($urandom));
			end
		end

		gaps_on = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			roll = $urandom_range(99);
			if (roll < 30)
				send(REQ_ALLOC, 10'($urandom));
			else if (roll < 70)
				send(REQ_FREE, 10'($urandom));
			else if (roll < 93)
				send(REQ_TEST, 10'($urandom));
			else
				send(REQ_NONE, 10'($urandom));
		end

		wait_all_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
src/bba_pkg.sv
src/bba_ffz.sv
src/bba_map.sv
src/bba_seq.sv
src/block_bitmap_allocator.sv
bench/block_bitmap_allocator_checker.sv
bench/block_bitmap_allocator_tb.sv
